/* sv/rfs_pkg.sv */
// ----------------------------------------------------------------------------
// rfs_pkg
// Shared types and constants for the run-queue / sleep-list scheduler.
// ----------------------------------------------------------------------------
package rfs_pkg;

  localparam int NumSlots = 16;
  localparam int IdW      = 4;
  localparam int CntW     = 5;
  localparam int TimeW    = 64;

  localparam logic [1:0] CMD_READY    = 2'd0;
  localparam logic [1:0] CMD_SLEEP    = 2'd1;
  localparam logic [1:0] CMD_SCHEDULE = 2'd2;
  localparam logic [1:0] CMD_RSVD     = 2'd3;

  localparam logic [1:0] ST_FLOATING = 2'd0;
  localparam logic [1:0] ST_READY    = 2'd1;
  localparam logic [1:0] ST_SLEEPING = 2'd2;

  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_NOT_FLOAT = 2'd1;
  localparam logic [1:0] STS_ZERO_WAIT = 2'd2;

  typedef struct packed {
    logic [IdW-1:0]   dispatch_id;
    logic             dispatch_valid;
    logic [CntW-1:0]  woken_count;
    logic [1:0]       status;
  } result_t;

endpackage

/* sv/rfs_cmp.sv */
// ----------------------------------------------------------------------------
// rfs_cmp
// Shared 64-bit unsigned less-than unit, registered result.
// ----------------------------------------------------------------------------
module rfs_cmp (
  input  logic                      clk,
  input  logic [rfs_pkg::TimeW-1:0] a,
  input  logic [rfs_pkg::TimeW-1:0] b,
  output logic                      lt_r
);

  always_ff @(posedge clk) begin
    lt_r <= (a < b);
  end

endmodule

/* sv/ready_fifo_sleep_timeout_scheduler_core.sv */
// ----------------------------------------------------------------------------
// ready_fifo_sleep_timeout_scheduler_core
// Task scheduler: FIFO run queue plus deadline-sorted sleep list.
//
// Input channel in_*: one command item (ready, sleep, schedule). Output
// channel out_*: one result item per command. The block takes one item at
// a time; in_ready is low from acceptance until the result is taken.
// Steps, accept to result: ready decodes and answers; sleep decodes,
// compares and checks entries until it finds the insertion point, shifts
// the tail up and places the sleeper; schedule decodes, compares and checks
// each sleeper, moves the remaining sleepers down when any woke, then pops
// the run queue. After the result is taken the block returns to idle.
// A single registered 64-bit compare unit, visited once per list entry,
// sets the walk time. Deadlines live in a slot-indexed register array.
// Reset empties both queues and makes every slot floating. If the receiver
// stalls, the result holds on out_* and no new item is taken.
// ----------------------------------------------------------------------------
module ready_fifo_sleep_timeout_scheduler_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [3:0]  in_proc_id,
  input  logic [62:0] in_wait_time,
  input  logic [63:0] in_now_time,
  input  logic        in_current_valid,
  input  logic [3:0]  in_current_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_dispatch_valid,
  output logic [3:0]  out_dispatch_id,
  output logic [4:0]  out_woken_count,
  output logic [1:0]  out_status
);

  localparam int IdW  = rfs_pkg::IdW;
  localparam int CntW = rfs_pkg::CntW;
  localparam int N    = rfs_pkg::NumSlots;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_SCMP = 4'd2;
  localparam logic [3:0] S_SCHK = 4'd3;
  localparam logic [3:0] S_SSH  = 4'd4;
  localparam logic [3:0] S_WCMP = 4'd5;
  localparam logic [3:0] S_WCHK = 4'd6;
  localparam logic [3:0] S_WSH  = 4'd7;
  localparam logic [3:0] S_POP  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]             state_r;
  logic [1:0]             cmd_r;
  logic [IdW-1:0]         pid_r;
  logic [62:0]            wait_r;
  logic [63:0]            now_r;
  logic                   curv_r;
  logic [IdW-1:0]         curid_r;
  logic [63:0]            dl_r;
  logic [1:0]             slot_state_r [N];
  logic [63:0]            slot_dl_r [N];
  logic [IdW-1:0]         run_fifo_r [N];
  logic [IdW-1:0]         sleep_r [N];
  logic [IdW-1:0]         run_head_r;
  logic [CntW-1:0]        run_count_r;
  logic [CntW-1:0]        sleep_count_r;
  logic [CntW-1:0]        pos_r;
  logic [CntW-1:0]        sh_r;
  rfs_pkg::result_t       res_r;

  logic [63:0]            cmp_a, cmp_b;
  logic                   lt_r;
  logic [IdW-1:0]         walk_id;
  logic [IdW-1:0]         tail_idx;

  assign walk_id  = sleep_r[pos_r[IdW-1:0]];
  assign tail_idx = run_head_r + run_count_r[IdW-1:0];

  // sleep walk: deadline < entry ; wake walk: entry < now
  always_comb begin
    if (state_r == S_SCMP) begin
      cmp_a = dl_r;
      cmp_b = slot_dl_r[walk_id];
    end else begin
      cmp_a = slot_dl_r[walk_id];
      cmp_b = now_r;
    end
  end

  rfs_cmp u_cmp (.clk(clk), .a(cmp_a), .b(cmp_b), .lt_r(lt_r));

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = (state_r == S_OUT);
  assign out_dispatch_valid = res_r.dispatch_valid;
  assign out_dispatch_id    = res_r.dispatch_id;
  assign out_woken_count    = res_r.woken_count;
  assign out_status         = res_r.status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      run_head_r    <= '0;
      run_count_r   <= '0;
      sleep_count_r <= '0;
      for (int i = 0; i < N; i++) begin
        slot_state_r[i] <= rfs_pkg::ST_FLOATING;
        slot_dl_r[i]    <= '0;
      end
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r   <= in_command;
            pid_r   <= in_proc_id;
            wait_r  <= in_wait_time;
            now_r   <= in_now_time;
            curv_r  <= in_current_valid;
            curid_r <= in_current_id;
            dl_r    <= in_now_time + {1'b0, in_wait_time};
            res_r   <= '0;
            pos_r   <= '0;
            state_r <= S_DEC;
          end
        end
        S_DEC: begin
          case (cmd_r)
            rfs_pkg::CMD_READY: begin
              if (slot_state_r[pid_r] != rfs_pkg::ST_FLOATING) begin
                res_r.status <= rfs_pkg::STS_NOT_FLOAT;
              end else begin
                slot_state_r[pid_r] <= rfs_pkg::ST_READY;
                if (run_count_r < CntW'(N)) begin
                  run_fifo_r[tail_idx] <= pid_r;
                  run_count_r          <= run_count_r + 1'b1;
                end
              end
              state_r <= S_OUT;
            end
            rfs_pkg::CMD_SLEEP: begin
              if (slot_state_r[pid_r] != rfs_pkg::ST_FLOATING) begin
                res_r.status <= rfs_pkg::STS_NOT_FLOAT;
                state_r      <= S_OUT;
              end else if (wait_r == '0) begin
                res_r.status <= rfs_pkg::STS_ZERO_WAIT;
                state_r      <= S_OUT;
              end else if (sleep_count_r >= CntW'(N)) begin
                state_r <= S_OUT;
              end else if (sleep_count_r == '0) begin
                state_r <= S_SSH;
                sh_r    <= '0;
              end else begin
                state_r <= S_SCMP;
              end
            end
            rfs_pkg::CMD_SCHEDULE: begin
              if (curv_r) begin
                if (slot_state_r[curid_r] != rfs_pkg::ST_FLOATING) begin
                  res_r.status <= rfs_pkg::STS_NOT_FLOAT;
                end else begin
                  slot_state_r[curid_r] <= rfs_pkg::ST_READY;
                  if (run_count_r < CntW'(N)) begin
                    run_fifo_r[tail_idx] <= curid_r;
                    run_count_r          <= run_count_r + 1'b1;
                  end
                end
              end
              state_r <= (sleep_count_r == '0) ? S_POP : S_WCMP;
            end
            default: state_r <= S_OUT;
          endcase
        end
        S_SCMP: state_r <= S_SCHK;
        S_SCHK: begin
          if (lt_r) begin
            sh_r    <= sleep_count_r;
            state_r <= S_SSH;
          end else if (pos_r + 1'b1 == sleep_count_r) begin
            pos_r   <= pos_r + 1'b1;
            sh_r    <= sleep_count_r;
            state_r <= S_SSH;
          end else begin
            pos_r   <= pos_r + 1'b1;
            state_r <= S_SCMP;
          end
        end
        S_SSH: begin
          // shift tail up one entry per cycle, then place
          if (sh_r > pos_r) begin
            sleep_r[sh_r[IdW-1:0]] <= sleep_r[sh_r[IdW-1:0] - 1'b1];
            sh_r <= sh_r - 1'b1;
          end else begin
            sleep_r[pos_r[IdW-1:0]] <= pid_r;
            sleep_count_r           <= sleep_count_r + 1'b1;
            slot_dl_r[pid_r]        <= dl_r;
            slot_state_r[pid_r]     <= rfs_pkg::ST_SLEEPING;
            state_r                 <= S_OUT;
          end
        end
        S_WCMP: state_r <= S_WCHK;
        S_WCHK: begin
          if (lt_r) begin
            slot_dl_r[walk_id]    <= '0;
            slot_state_r[walk_id] <= rfs_pkg::ST_READY;
            if (run_count_r < CntW'(N)) begin
              run_fifo_r[tail_idx] <= walk_id;
              run_count_r          <= run_count_r + 1'b1;
            end
            pos_r <= pos_r + 1'b1;
            res_r.woken_count <= res_r.woken_count + 1'b1;
            if (pos_r + 1'b1 == sleep_count_r) begin
              sh_r    <= '0;
              state_r <= S_WSH;
            end else begin
              state_r <= S_WCMP;
            end
          end else begin
            sh_r    <= '0;
            state_r <= (pos_r == '0) ? S_POP : S_WSH;
          end
        end
        S_WSH: begin
          // move remaining sleepers down by pos_r, one per cycle
          if (sh_r + pos_r < sleep_count_r) begin
            sleep_r[sh_r[IdW-1:0]] <= sleep_r[IdW'(sh_r + pos_r)];
            sh_r <= sh_r + 1'b1;
          end else begin
            sleep_count_r <= sleep_count_r - pos_r;
            state_r       <= S_POP;
          end
        end
        S_POP: begin
          if (run_count_r != '0) begin
            slot_state_r[run_fifo_r[run_head_r]] <= rfs_pkg::ST_FLOATING;
            res_r.dispatch_valid <= 1'b1;
            res_r.dispatch_id    <= run_fifo_r[run_head_r];
            run_head_r           <= run_head_r + 1'b1;
            run_count_r          <= run_count_r - 1'b1;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_cnt_run: assert property (@(posedge clk) disable iff (!rst_n)
    run_count_r <= CntW'(N)) else $error("run count overflow");
  a_cnt_sleep: assert property (@(posedge clk) disable iff (!rst_n)
    sleep_count_r <= CntW'(N)) else $error("sleep count overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(res_r)) else $error("result changed");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("accepted while busy");

endmodule

/* test/tb_ready_fifo_sleep_timeout_scheduler_core.sv */
// ----------------------------------------------------------------------------
// tb_ready_fifo_sleep_timeout_scheduler_core
// Self-checking bench for the run-queue / sleep-list scheduler. A local
// model tracks slot states, deadlines and both queues and predicts each
// result; directed cases cover errors, wrap and empty queues, then random
// command mixes run under three idle profiles and a long output stall.
// ----------------------------------------------------------------------------
module tb_ready_fifo_sleep_timeout_scheduler_core;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       dvalid;
    logic [3:0] did;
    logic [4:0] woken;
    logic [1:0] status;
  } sched_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_command = '0;
  logic [3:0] in_proc_id = '0;
  logic [62:0] in_wait_time = '0;
  logic [63:0] in_now_time = '0;
  logic in_current_valid = 1'b0;
  logic [3:0] in_current_id = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_dispatch_valid;
  logic [3:0] out_dispatch_id;
  logic [4:0] out_woken_count;
  logic [1:0] out_status;

  ready_fifo_sleep_timeout_scheduler_core u_top (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // model state
  logic [1:0] slot_st[rfs_pkg::NumSlots];
  logic [63:0] slot_dl[rfs_pkg::NumSlots];
  logic [3:0] run_q[$];
  logic [3:0] sleep_list[$];
  sched_res_t expected_q[$];
  int errors = 0;
  int n_items = 0;
  int n_dispatch = 0;
  int n_woken = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off = 0;
  logic [63:0] clock_now = 64'd1000;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, exp, $time);
    errors++;
  endtask

  function automatic void enqueue_run(input logic [3:0] id);
    slot_st[id] = rfs_pkg::ST_READY;
    if (run_q.size() < rfs_pkg::NumSlots) run_q.push_back(id);
  endfunction

  function automatic sched_res_t predict_step(input logic [1:0] cmd, input logic [3:0] pid,
                                              input logic [62:0] wt, input logic [63:0] now,
                                              input logic cv, input logic [3:0] cid);
    sched_res_t r;
    logic [63:0] dl;
    int pos;
    r = '0;
    r.status = rfs_pkg::STS_OK;
    case (cmd)
      rfs_pkg::CMD_READY: begin
        if (slot_st[pid] != rfs_pkg::ST_FLOATING) r.status = rfs_pkg::STS_NOT_FLOAT;
        else enqueue_run(pid);
      end
      rfs_pkg::CMD_SLEEP: begin
        if (slot_st[pid] != rfs_pkg::ST_FLOATING) r.status = rfs_pkg::STS_NOT_FLOAT;
        else if (wt == '0) r.status = rfs_pkg::STS_ZERO_WAIT;
        else if (sleep_list.size() < rfs_pkg::NumSlots) begin
          dl = now + {1'b0, wt};
          pos = 0;
          while (pos < sleep_list.size() && !(dl < slot_dl[sleep_list[pos]])) pos++;
          sleep_list.insert(pos, pid);
          slot_dl[pid] = dl;
          slot_st[pid] = rfs_pkg::ST_SLEEPING;
        end
      end
      rfs_pkg::CMD_SCHEDULE: begin
        if (cv) begin
          if (slot_st[cid] == rfs_pkg::ST_FLOATING) enqueue_run(cid);
          else r.status = rfs_pkg::STS_NOT_FLOAT;
        end
        while (sleep_list.size() > 0 && slot_dl[sleep_list[0]] < now) begin
          slot_dl[sleep_list[0]] = '0;
          enqueue_run(sleep_list.pop_front());
          r.woken++;
        end
        if (run_q.size() > 0) begin
          r.dvalid = 1'b1;
          r.did = run_q.pop_front();
          slot_st[r.did] = rfs_pkg::ST_FLOATING;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_cmd(input logic [1:0] cmd, input logic [3:0] pid, input logic [62:0] wt,
                          input logic [63:0] now, input logic cv, input logic [3:0] cid);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid <= 1'b1;
    in_command <= cmd;
    in_proc_id <= pid;
    in_wait_time <= wt;
    in_now_time <= now;
    in_current_valid <= cv;
    in_current_id <= cid;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(predict_step(cmd, pid, wt, now, cv, cid));
    n_items++;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (expected_q.size() > 0) @(negedge clk);
  endtask

  // receiver
  initial begin
    forever begin
      @(negedge clk);
      out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result checker
  initial begin
    sched_res_t e;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected item", 32'(out_dispatch_id), 32'd0);
        end else begin
          e = expected_q.pop_front();
          if (out_dispatch_valid !== e.dvalid)
            report("dispatch_valid", 32'(out_dispatch_valid), 32'(e.dvalid));
          if (out_dispatch_id !== e.did)
            report("dispatch_id", 32'(out_dispatch_id), 32'(e.did));
          if (out_woken_count !== e.woken)
            report("woken_count", 32'(out_woken_count), 32'(e.woken));
          if (out_status !== e.status)
            report("status", 32'(out_status), 32'(e.status));
          if (e.dvalid) n_dispatch++;
          n_woken += e.woken;
        end
      end
    end
  end

  task automatic test_directed();
    send_cmd(rfs_pkg::CMD_SCHEDULE, 4'd0, '0, 64'd0, 1'b0, 4'd0);
    send_cmd(rfs_pkg::CMD_READY, 4'd0, '0, 64'd0, 1'b0, 4'd0);
    send_cmd(rfs_pkg::CMD_READY, 4'd0, '0, 64'd0, 1'b0, 4'd0);
    send_cmd(rfs_pkg::CMD_SLEEP, 4'd0, 63'd5, 64'd0, 1'b0, 4'd0);
    send_cmd(rfs_pkg::CMD_SLEEP, 4'd15, '0, 64'd0, 1'b0, 4'd0);
    send_cmd(rfs_pkg::CMD_SLEEP, 4'd15, '1, '1, 1'b0, 4'd0);
    send_cmd(rfs_pkg::CMD_SLEEP, 4'd3, 63'd10, 64'd100, 1'b0, 4'd0);
    send_cmd(rfs_pkg::CMD_SLEEP, 4'd4, 63'd10, 64'd100, 1'b0, 4'd0);
    send_cmd(rfs_pkg::CMD_SLEEP, 4'd5, 63'd5, 64'd100, 1'b0, 4'd0);
    send_cmd(rfs_pkg::CMD_RSVD, 4'd7, '1, '1, 1'b1, 4'd7);
    send_cmd(rfs_pkg::CMD_SCHEDULE, 4'd0, '0, 64'd110, 1'b1, 4'd3);
    send_cmd(rfs_pkg::CMD_SCHEDULE, 4'd0, '0, 64'd111, 1'b1, 4'd9);
    send_cmd(rfs_pkg::CMD_SCHEDULE, 4'd0, '0, '1, 1'b1, 4'd15);
    send_cmd(rfs_pkg::CMD_SCHEDULE, 4'd0, '0, 64'd0, 1'b0, 4'd0);
    send_cmd(rfs_pkg::CMD_SCHEDULE, 4'd0, '0, 64'd0, 1'b0, 4'd0);
    send_cmd(rfs_pkg::CMD_SCHEDULE, 4'd0, '0, 64'd0, 1'b0, 4'd0);
    send_cmd(rfs_pkg::CMD_SCHEDULE, 4'd0, '0, 64'd0, 1'b0, 4'd0);
    send_cmd(rfs_pkg::CMD_SCHEDULE, 4'd0, '0, '1, 1'b0, 4'd0);
    wait_drain();
  endtask

  task automatic random_cmd();
    int sel;
    logic [62:0] wt;
    logic [63:0] now;
    logic [62:0] rwt;
    logic [63:0] rnow;
    logic [3:0] rpid;
    logic [3:0] rcid;
    logic rcv;
    sel = int'($urandom_range(99));
    clock_now += 64'($urandom_range(40));
    now = clock_now;
    if ($urandom_range(19) == 0) now = {$urandom, $urandom};
    case ($urandom_range(3))
      0: wt = 63'({$urandom, $urandom});
      1: wt = '0;
      default: wt = 63'($urandom_range(60, 1));
    endcase
    rwt = 63'({$urandom, $urandom});
    rnow = {$urandom, $urandom};
    rpid = 4'($urandom_range(15));
    rcid = 4'($urandom_range(15));
    rcv = 1'($urandom_range(1));
    if (sel < 30) send_cmd(rfs_pkg::CMD_READY, rpid, rwt, rnow, rcv, rcid);
    else if (sel < 60) send_cmd(rfs_pkg::CMD_SLEEP, rpid, wt, now, rcv, rcid);
    else if (sel < 97) send_cmd(rfs_pkg::CMD_SCHEDULE, rpid, rwt, now, rcv, rcid);
    else send_cmd(rfs_pkg::CMD_RSVD, rpid, rwt, rnow, rcv, rcid);
  endtask

  task automatic test_random(input int count, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (count) random_cmd();
    wait_drain();
  endtask

  task automatic test_backpressure();
    int stall_cycles;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      begin
        hold_off = 1;
        stall_cycles = 0;
        while (stall_cycles < 400) begin
          @(negedge clk);
          stall_cycles++;
        end
        hold_off = 0;
      end
      repeat (20) random_cmd();
    join
    wait_drain();
    repeat (30) random_cmd();
    wait_drain();
  endtask

  initial begin
    for (int i = 0; i < rfs_pkg::NumSlots; i++) begin
      slot_st[i] = rfs_pkg::ST_FLOATING;
      slot_dl[i] = '0;
    end
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(440, 7, 47);
    test_random(440, 47, 7);
    test_random(400, 0, 0);
    test_backpressure();
    repeat (100) @(negedge clk);
    $display("Ran %0d commands: %0d dispatches, %0d sleepers woken.", n_items, n_dispatch, n_woken);
    $display("Covered ready/sleep/schedule, error codes, deadline wrap and output stalls.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* sim.f */
sv/rfs_pkg.sv
sv/rfs_cmp.sv
sv/ready_fifo_sleep_timeout_scheduler_core.sv
test/tb_ready_fifo_sleep_timeout_scheduler_core.sv
